FILE: hdl/gmn_pkg.sv
// Shared types and constants for the GF(2) matrix nullity block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gmn_pkg;

  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ROW_W    = 64;
  localparam int unsigned SUBSET_W = 30;

  localparam logic [COUNT_W-1:0]  COLS_RESET = 7'd64;
  localparam logic [SUBSET_W:0]   PRIME_MOD  = 31'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_XOR,
    ST_FIN,
    ST_POW
  } gmn_state_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] exponent;
  } pow_req_t;

  typedef struct packed {
    logic                busy;
    logic [SUBSET_W-1:0] value;
  } pow_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/gmn_if.sv
// Channel interfaces for the GF(2) matrix nullity block: row input and result output.
// Depends on gmn_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gmn_in_if import gmn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_bits;
  logic             last_row;

  modport source (output valid, output row_bits, output last_row, input ready);
  modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

interface gmn_out_if import gmn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  free_count;
  logic [COUNT_W-1:0]  rank_value;
  logic [SUBSET_W-1:0] subset_count;

  modport source (output valid, output free_count, output rank_value,
                  output subset_count, input ready);
  modport sink (input valid, input free_count, input rank_value,
                input subset_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/gmn_pow2_mod.sv
// Iterative unit that computes 2^e modulo the prime, one doubling per cycle.
// Depends on gmn_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module gmn_pow2_mod import gmn_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  pow_req_t req,
  output pow_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUBSET_W-1:0] acc_r, acc_nxt;
  logic [SUBSET_W:0]   dbl;

  always_comb begin
    dbl      = {acc_r, 1'b0};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.exponent;
      acc_nxt  = SUBSET_W'(1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - COUNT_W'(1);
        if (dbl >= PRIME_MOD) begin
          acc_nxt = SUBSET_W'(dbl - PRIME_MOD);
        end else begin
          acc_nxt = SUBSET_W'(dbl);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.value = acc_r;

endmodule

`default_nettype wire

FILE: hdl/gf2_matrix_nullity.sv
// GF(2) rank and nullity of a binary matrix streamed in one row per beat.
// Depends on gmn_pkg, gmn_if (channel interfaces) and gmn_pow2_mod.
//
// Usage: write column_count through cfg_we/cfg_data while the block is idle
// (reset value 64, values above MAX_COLUMNS saturate). Send the rows of a
// matrix on in_ch, one row per beat, with last_row set on the final row.
// A matrix with no equations is sent as one all-zero row with last_row set.
// Each row is reduced against a basis memory indexed by pivot column, from the
// highest column down. A column whose bit is clear is skipped; one that is
// cancelled by a basis row takes a memory read (ST_SCAN), then the XOR
// (ST_XOR). A set bit with no basis row becomes a new pivot and ends the scan;
// in_ch.ready stays low from the row's beat until its scan ends. After the
// last row, ST_FIN clears the basis and starts the doubling unit, which stays
// busy until it has computed 2^free_count. Once the unit is idle and the
// previous result has drained, ST_POW loads the result register, so the beat
// is offered on out_ch in the same cycle as in_ch.ready rises. The result
// sits in an output register, so the next matrix may start while the receiver
// stalls; only the next result waits for it to drain. Reset (rst_n low at a
// clock edge) clears the basis valid bits, the rank and the output valid bit.
`timescale 1ns / 1ps
`default_nettype none

module gf2_matrix_nullity import gmn_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [COUNT_W-1:0]  cfg_data,
  gmn_in_if.sink             in_ch,
  gmn_out_if.source          out_ch
);

  localparam int unsigned IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  gmn_state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]       cfg_cols_r;
  logic [COUNT_W-1:0]       cols;
  logic [MAX_COLUMNS-1:0]   col_mask;
  logic [MAX_COLUMNS-1:0]   row_r, row_nxt;
  logic [IDX_W-1:0]         col_r, col_nxt;
  logic                     last_r, last_nxt;
  logic [MAX_COLUMNS-1:0]   valid_r, valid_nxt;
  logic [COUNT_W-1:0]       rank_r, rank_nxt;
  logic [COUNT_W-1:0]       rank_sat;
  logic [COUNT_W-1:0]       res_free_r, res_free_nxt;
  logic [COUNT_W-1:0]       res_rank_r, res_rank_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]       out_free_r, out_free_nxt;
  logic [COUNT_W-1:0]       out_rank_r, out_rank_nxt;
  logic [SUBSET_W-1:0]      out_subset_r, out_subset_nxt;
  logic                     mem_we, mem_re;
  logic [MAX_COLUMNS-1:0]   rd_r;
  logic [MAX_COLUMNS-1:0]   basis_mem [MAX_COLUMNS];
  logic                     scan_done;
  pow_req_t                 pow_req;
  pow_rsp_t                 pow_rsp;

  always_comb begin
    cols = (cfg_cols_r > COUNT_W'(MAX_COLUMNS)) ? COUNT_W'(MAX_COLUMNS) : cfg_cols_r;
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      col_mask[j] = (COUNT_W'(j) < cols);
    end
    rank_sat = (rank_r > cols) ? cols : rank_r;
  end

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    last_nxt       = last_r;
    valid_nxt      = valid_r;
    rank_nxt       = rank_r;
    res_free_nxt   = res_free_r;
    res_rank_nxt   = res_rank_r;
    out_valid_nxt  = out_valid_r;
    out_free_nxt   = out_free_r;
    out_rank_nxt   = out_rank_r;
    out_subset_nxt = out_subset_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    scan_done      = 1'b0;
    pow_req        = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          row_nxt  = in_ch.row_bits[MAX_COLUMNS-1:0] & col_mask;
          last_nxt = in_ch.last_row;
          col_nxt  = IDX_W'(cols - COUNT_W'(1));
          if (cols == '0) begin
            state_nxt = in_ch.last_row ? ST_FIN : ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!row_r[col_r]) begin
          if (col_r == '0) begin
            scan_done = 1'b1;
          end else begin
            col_nxt = col_r - IDX_W'(1);
          end
        end else if (valid_r[col_r]) begin
          mem_re    = 1'b1;
          state_nxt = ST_XOR;
        end else begin
          mem_we           = 1'b1;
          valid_nxt[col_r] = 1'b1;
          rank_nxt         = rank_r + COUNT_W'(1);
          scan_done        = 1'b1;
        end
      end
      ST_XOR: begin
        row_nxt = row_r ^ rd_r;
        if (col_r == '0) begin
          scan_done = 1'b1;
        end else begin
          col_nxt   = col_r - IDX_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_FIN: begin
        res_rank_nxt     = rank_sat;
        res_free_nxt     = cols - rank_sat;
        pow_req.start    = 1'b1;
        pow_req.exponent = cols - rank_sat;
        valid_nxt        = '0;
        rank_nxt         = '0;
        state_nxt        = ST_POW;
      end
      ST_POW: begin
        if (!pow_rsp.busy && (!out_valid_r || out_ch.ready)) begin
          out_valid_nxt  = 1'b1;
          out_free_nxt   = res_free_r;
          out_rank_nxt   = res_rank_r;
          out_subset_nxt = pow_rsp.value - SUBSET_W'(1);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (scan_done) begin
      state_nxt = last_r ? ST_FIN : ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_cols_r  <= COLS_RESET;
      valid_r     <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cfg_cols_r <= cfg_data;
      end
      valid_r     <= valid_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    last_r       <= last_nxt;
    res_free_r   <= res_free_nxt;
    res_rank_r   <= res_rank_nxt;
    out_free_r   <= out_free_nxt;
    out_rank_r   <= out_rank_nxt;
    out_subset_r <= out_subset_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      basis_mem[col_r] <= row_r;
    end
    if (mem_re) begin
      rd_r <= basis_mem[col_r];
    end
  end

  gmn_pow2_mod u_pow (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pow_req),
    .rsp   (pow_rsp)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.free_count   = out_free_r;
  assign out_ch.rank_value   = out_rank_r;
  assign out_ch.subset_count = out_subset_r;

  a_rank_matches_pivots: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(rank_r))
    else $error("rank counter disagrees with pivot valid bits");

  a_xor_reads_valid_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_XOR) |-> valid_r[col_r])
    else $error("basis row used without a valid pivot");

  a_fin_clears_basis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (valid_r == '0 && rank_r == '0 && pow_rsp.busy))
    else $error("basis not cleared or power unit not started after last row");

  a_result_waits_for_pow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POW && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("result not presented when leaving the power step");

endmodule

`default_nettype wire

FILE: test/gf2_matrix_nullity_tb.sv
// Self-checking testbench for gf2_matrix_nullity: streams binary matrices row by row and checks
// rank, free count and 2^free - 1 mod 1000000007 against an internal GF(2) elimination.
// Depends on gmn_pkg, gmn_if and the gf2_matrix_nullity RTL.
`timescale 1ns / 1ps

module gf2_matrix_nullity_tb;
  import gmn_pkg::*;

  localparam longint unsigned SUBSET_MOD = 64'd1000000007;
  localparam int ROW_TARGET = 950;
  localparam int QUIET_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_GAP = 13;

  typedef struct {
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  rank_value;
    logic [SUBSET_W-1:0] subset_count;
  } nullity_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [COUNT_W-1:0] cfg_data;

  gmn_in_if  in_ch ();
  gmn_out_if out_ch ();

  gf2_matrix_nullity u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  logic [ROW_W-1:0]   basis_row [64];
  logic               pivot_seen [64];
  int unsigned        rank_tally;
  logic [COUNT_W-1:0] col_setting;
  nullity_t           pending_nullity [$];
  logic [ROW_W-1:0]   recent_rows [$];

  int  error_count;
  int  rows_sent;
  int  results_checked;
  int  settings_used;
  int  stall_cycles;
  bit  in_calm;
  bit  out_calm;

  always #4 clk = ~clk;

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [SUBSET_W-1:0] subsets_mod(int unsigned free_vars);
    longint unsigned acc;
    acc = 1;
    for (int i = 0; i < free_vars; i++) acc = (acc * 2) % SUBSET_MOD;
    acc = (acc + SUBSET_MOD - 1) % SUBSET_MOD;
    return acc[SUBSET_W-1:0];
  endfunction

  function automatic void clear_basis();
    for (int i = 0; i < 64; i++) pivot_seen[i] = 1'b0;
    rank_tally = 0;
  endfunction

  // Reduces one accepted row against the basis and queues a result on the final row.
  function automatic void absorb_row(logic [ROW_W-1:0] row_in, logic last);
    int act;
    int rk;
    logic [ROW_W-1:0] row;
    nullity_t res;
    act = (col_setting > 64) ? 64 : int'(col_setting);
    row = (act >= 64) ? row_in : (row_in & ((64'd1 << act) - 64'd1));
    for (int c = act - 1; c >= 0; c--) begin
      if (row[c]) begin
        if (pivot_seen[c]) begin
          row = row ^ basis_row[c];
        end else begin
          basis_row[c] = row;
          pivot_seen[c] = 1'b1;
          if (rank_tally < 64) rank_tally++;
          break;
        end
      end
    end
    if (last) begin
      rk = (rank_tally > act) ? act : int'(rank_tally);
      res.free_count = COUNT_W'(act - rk);
      res.rank_value = COUNT_W'(rk);
      res.subset_count = subsets_mod(act - rk);
      pending_nullity.push_back(res);
      clear_basis();
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_row(logic [ROW_W-1:0] row, logic last);
    int gap;
    gap = draw_gap(in_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.row_bits = row;
    in_ch.last_row = last;
    do @(posedge clk); while (!in_ch.ready);
    absorb_row(row, last);
    rows_sent++;
  endtask

  // Holds the input off until every result is back and any row in flight is done.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_nullity.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_columns(logic [COUNT_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    col_setting = value;
    settings_used++;
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      1: r = 64'd1 << $urandom_range(0, 63);
      2: begin
        if (recent_rows.size() > 1) begin
          r = recent_rows[$urandom_range(0, recent_rows.size() - 1)]
            ^ recent_rows[$urandom_range(0, recent_rows.size() - 1)];
        end
      end
      3: r = $urandom_range(0, 1) ? '0 : '1;
      default: ;
    endcase
    return r;
  endfunction

  initial begin : result_sink
    int gap;
    nullity_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(out_calm);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_nullity.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = pending_nullity.pop_front();
        if (out_ch.free_count !== want.free_count)
          report_mismatch("free_count", out_ch.free_count, want.free_count);
        if (out_ch.rank_value !== want.rank_value)
          report_mismatch("rank_value", out_ch.rank_value, want.rank_value);
        if (out_ch.subset_count !== want.subset_count)
          report_mismatch("subset_count", out_ch.subset_count, want.subset_count);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles at %0t.", stall_cycles, $realtime);
      $display("gf2_matrix_nullity_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_columns();
    send_row('0, 1'b1);
    send_row('1, 1'b1);
    send_row(64'd1, 1'b1);
  endtask

  task automatic test_dependent_rows();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = 64'hF0F0_1234_0000_8001;
    b = 64'h0FF0_8000_5555_0002;
    send_row(64'd1 << 63, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    send_row(a, 1'b0);
    send_row(b, 1'b0);
    send_row(a ^ b, 1'b1);
  endtask

  task automatic test_column_extremes();
    settle_block();
    set_columns(7'd1);
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    settle_block();
    set_columns(7'd0);
    send_row('1, 1'b1);
    settle_block();
    set_columns(7'd127);
    send_row('0, 1'b1);
    settle_block();
    set_columns(7'd65);
    send_row('1, 1'b0);
    send_row('0, 1'b1);
    settle_block();
    set_columns(7'd8);
    send_row(64'hFFFF_FFFF_FFFF_FF00, 1'b1);
  endtask

  task automatic test_shrink_mid_matrix();
    settle_block();
    set_columns(7'd64);
    for (int i = 0; i < 5; i++) send_row(64'd1 << (63 - i), 1'b0);
    settle_block();
    set_columns(7'd3);
    send_row(64'd7, 1'b1);
  endtask

  task automatic test_random_matrices();
    int n_mat;
    int n_rows;
    bit open_end;
    logic [ROW_W-1:0] r;
    logic [COUNT_W-1:0] pick;
    while (rows_sent < ROW_TARGET) begin
      settle_block();
      case ($urandom_range(0, 9))
        0: pick = 7'd0;
        1: pick = 7'd64;
        2: pick = COUNT_W'($urandom_range(65, 127));
        3: pick = 7'd1;
        default: pick = COUNT_W'($urandom_range(1, 64));
      endcase
      set_columns(pick);
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      n_mat = $urandom_range(3, 12);
      open_end = ($urandom_range(0, 4) == 0);
      for (int m = 0; m < n_mat; m++) begin
        n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 70) : $urandom_range(1, 6);
        for (int k = 0; k < n_rows; k++) begin
          r = random_row();
          recent_rows.push_back(r);
          if (recent_rows.size() > 8) void'(recent_rows.pop_front());
          send_row(r, (k == n_rows - 1) && !(open_end && m == n_mat - 1));
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.row_bits = '0;
    in_ch.last_row = 1'b0;
    error_count = 0;
    rows_sent = 0;
    results_checked = 0;
    settings_used = 0;
    stall_cycles = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    col_setting = COLS_RESET;
    clear_basis();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_columns();
    test_dependent_rows();
    test_column_extremes();
    test_shrink_mid_matrix();
    test_random_matrices();

    settle_block();
    $display("Sent %0d rows; checked %0d matrix results over %0d column settings,",
             rows_sent, results_checked, settings_used);
    $display("including zero, one, full and saturated widths and a width cut mid-matrix.");
    if (error_count == 0) begin
      $display("gf2_matrix_nullity_tb: done, clean");
    end else begin
      $display("gf2_matrix_nullity_tb: done, errors");
    end
    $finish;
  end

endmodule
